// ===== rtl/core/mqsb_pkg.sv =====
package mqsb_pkg;

  localparam int unsigned NUM_QUEUES_DEF = 4;
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_W         = 32;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_SLOT
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         queue_id;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] data;
    logic               store_full;
    logic               queue_empty;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic slot_rd;
    logic commit_enq;
    logic commit_deq;
    logic commit_miss;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_deq;
    logic queue_nonempty;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/mqsb_stream_if.sv =====
interface mqsb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/multi_queue_shared_buffer_unit.sv =====
// Several FIFO queues share one store of DEPTH data slots. Each word in is
// an enqueue (kind 0: value into queue queue_id) or a dequeue (kind 1), and
// each gives one result word: status ok/overflow/underflow, the dequeued
// data (-1 on underflow, 0 for enqueue), store_full and queue_empty for the
// state after the operation. A queue_id at or above NUM_QUEUES wraps modulo
// NUM_QUEUES. Words are processed one at a time: an enqueue, overflow or
// underflow passes through the pointer read state, a good dequeue through
// the pointer read and then the slot read state, and each waits in its last
// state while the output register still holds an unaccepted result. This
// order is set by the registered pointer rams (head/tail) followed by the
// registered link/data read of the head slot. The result sits in an output
// register, so the next word is taken while it waits. There is no clearing
// pass after reset: slots never used yet are tracked by a fill mark and
// form the tail of the free list, so the link ram needs no initial contents.
module multi_queue_shared_buffer_unit #(
  parameter int unsigned NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
  parameter int unsigned DEPTH      = mqsb_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mqsb_stream_if.sink   in_i,
  mqsb_stream_if.source out_o
);

  // command and status between sequencer and datapath
  mqsb_pkg::cmd_t cmd;
  mqsb_pkg::sts_t sts;

  logic                in_ready;
  logic                out_valid;
  mqsb_pkg::out_word_t out_word;

  // sequencer: idle, pointer read, slot read
  mqsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // pointer/link/data rams, free list and output register
  mqsb_dp #(
    .NUM_QUEUES (NUM_QUEUES),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  // ready only while the sequencer is idle
  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_word;

endmodule

// ===== rtl/core/mqsb_ram.sv =====
module mqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mqsb_ctrl.sv =====
module mqsb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mqsb_pkg::sts_t     sts_i,
  output mqsb_pkg::cmd_t     cmd_o
);

  mqsb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqsb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mqsb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mqsb_pkg::S_PTR;
        end
      end
      mqsb_pkg::S_PTR: begin
        if (!sts_i.is_deq) begin
          if (sts_i.out_free) begin
            cmd_o.commit_enq = 1'b1;
            state_d          = mqsb_pkg::S_IDLE;
          end
        end else if (!sts_i.queue_nonempty) begin
          if (sts_i.out_free) begin
            cmd_o.commit_miss = 1'b1;
            state_d           = mqsb_pkg::S_IDLE;
          end
        end else begin
          cmd_o.slot_rd = 1'b1;
          state_d       = mqsb_pkg::S_SLOT;
        end
      end
      mqsb_pkg::S_SLOT: begin
        if (sts_i.out_free) begin
          cmd_o.commit_deq = 1'b1;
          state_d          = mqsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mqsb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mqsb_dp.sv =====
module mqsb_dp #(
  parameter int unsigned NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
  parameter int unsigned DEPTH      = mqsb_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mqsb_pkg::in_word_t  in_word_i,
  input  mqsb_pkg::cmd_t      cmd_i,
  output mqsb_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mqsb_pkg::out_word_t out_word_o
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);
  localparam int unsigned DW = mqsb_pkg::DATA_W;

  // queue number folded into range
  function automatic logic [QW-1:0] qmod(input logic [1:0] id);
    logic [7:0] v;
    v = {6'd0, id};
    for (int i = 0; i < 4; i++) begin
      if (v >= 8'(NUM_QUEUES)) begin
        v = v - 8'(NUM_QUEUES);
      end
    end
    return v[QW-1:0];
  endfunction

  // latched operation
  mqsb_pkg::kind_e kind_q;
  logic [QW-1:0]   qsel_q;
  logic [DW-1:0]   value_q;

  // control state
  logic [PW-1:0]         fh_q, fh_d;
  logic [PW-1:0]         fresh_q, fresh_d;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;

  logic                out_valid_q, out_valid_d;
  mqsb_pkg::out_word_t out_q, out_d;

  // ram read data
  logic [SW-1:0] head_rd, tail_rd;
  logic [PW-1:0] link_rd;
  logic [DW-1:0] data_rd;

  // ram write ports
  logic          head_we, tail_we, link_we, data_we;
  logic [QW-1:0] head_waddr;
  logic [SW-1:0] head_wdata, tail_wdata, link_waddr, data_waddr;
  logic [PW-1:0] link_wdata;
  logic [QW-1:0] ptr_raddr;
  logic [SW-1:0] link_raddr;

  logic          out_free;
  logic          have_slot, from_fresh, last_one;
  logic [SW-1:0] slot;
  logic [PW-1:0] fh_alloc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign ptr_raddr  = qmod(in_word_i.queue_id);
  assign link_raddr = cmd_i.load ? fh_q[SW-1:0] : head_rd;

  assign have_slot  = (fh_q != NIL);
  assign slot       = fh_q[SW-1:0];
  assign from_fresh = (fh_q >= fresh_q);
  assign fh_alloc   = from_fresh ? (fh_q + PW'(1)) : link_rd;
  assign last_one   = (head_rd == tail_rd);

  assign sts_o.is_deq         = (kind_q == mqsb_pkg::KIND_DEQ);
  assign sts_o.queue_nonempty = nonempty_q[qsel_q];
  assign sts_o.out_free       = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_word_i.kind;
      qsel_q  <= ptr_raddr;
      value_q <= in_word_i.value;
    end
  end

  always_comb begin
    fh_d        = fh_q;
    fresh_d     = fresh_q;
    nonempty_d  = nonempty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    head_we     = 1'b0;
    tail_we     = 1'b0;
    link_we     = 1'b0;
    data_we     = 1'b0;
    head_waddr  = qsel_q;
    head_wdata  = slot;
    tail_wdata  = slot;
    link_waddr  = tail_rd;
    link_wdata  = PW'(slot);
    data_waddr  = slot;

    if (cmd_i.commit_enq) begin
      out_valid_d       = 1'b1;
      out_d.data        = '0;
      if (have_slot) begin
        data_we           = 1'b1;
        tail_we           = 1'b1;
        link_we           = nonempty_q[qsel_q];
        head_we           = !nonempty_q[qsel_q];
        nonempty_d[qsel_q] = 1'b1;
        fh_d              = fh_alloc;
        if (from_fresh) begin
          fresh_d = fh_q + PW'(1);
        end
        out_d.status      = mqsb_pkg::ST_OK;
        out_d.store_full  = (fh_alloc == NIL);
        out_d.queue_empty = 1'b0;
      end else begin
        out_d.status      = mqsb_pkg::ST_OVERFLOW;
        out_d.store_full  = 1'b1;
        out_d.queue_empty = !nonempty_q[qsel_q];
      end
    end

    if (cmd_i.commit_deq) begin
      // head slot goes to the front of the free list
      link_we            = 1'b1;
      link_waddr         = head_rd;
      link_wdata         = fh_q;
      head_we            = !last_one;
      head_wdata         = link_rd[SW-1:0];
      nonempty_d[qsel_q] = !last_one;
      fh_d               = PW'(head_rd);
      out_valid_d        = 1'b1;
      out_d.status       = mqsb_pkg::ST_OK;
      out_d.data         = data_rd;
      out_d.store_full   = 1'b0;
      out_d.queue_empty  = last_one;
    end

    if (cmd_i.commit_miss) begin
      out_valid_d       = 1'b1;
      out_d.status      = mqsb_pkg::ST_UNDERFLOW;
      out_d.data        = '1;
      out_d.store_full  = !have_slot;
      out_d.queue_empty = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q        <= '0;
      fresh_q     <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fh_q        <= fh_d;
      fresh_q     <= fresh_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (ptr_raddr),
    .rdata_o (head_rd)
  );

  mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (qsel_q),
    .wdata_i (tail_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (ptr_raddr),
    .rdata_o (tail_rd)
  );

  mqsb_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.load || cmd_i.slot_rd),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  mqsb_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (value_q),
    .re_i    (cmd_i.slot_rd),
    .raddr_i (head_rd),
    .rdata_o (data_rd)
  );

  // never commit over a result that is still waiting
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_enq || cmd_i.commit_deq || cmd_i.commit_miss) |-> out_free)
    else $error("result committed while output register busy");

  // untouched slots stay on the free list, so an empty free list means none remain
  a_free_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fh_q == NIL) |-> (fresh_q == NIL))
    else $error("free list empty with fresh slots left");

  // free head never points past the fresh mark
  a_fh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q <= NIL) && ((fh_q == NIL) || (fh_q <= fresh_q)))
    else $error("free head or fresh mark out of range");

  // a successful enqueue always leaves its queue non-empty
  a_enq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_enq && have_slot) |=> nonempty_q[$past(qsel_q)])
    else $error("queue empty after enqueue");

endmodule
